FILE: src/stkd_pkg.sv
// Package for the serial terminal key decoder.
// Holds the front-to-back command word, character codes and key codes.
// No dependencies.
package stkd_pkg;

	// Character codes seen by the parser
	localparam logic [7:0] ASC_ESC   = 8'h1B;
	localparam logic [7:0] ASC_BS    = 8'h08;
	localparam logic [7:0] ASC_TAB   = 8'h09;
	localparam logic [7:0] ASC_LF    = 8'h0A;
	localparam logic [7:0] ASC_CR    = 8'h0D;
	localparam logic [7:0] ASC_SPACE = 8'h20;
	localparam logic [7:0] ASC_LBRK  = 8'h5B;
	localparam logic [7:0] ASC_SS3   = 8'h4F;
	localparam logic [7:0] ASC_LC_A  = 8'h61;
	localparam logic [7:0] ASC_LC_Z  = 8'h7A;
	localparam logic [7:0] ASC_UP    = 8'h41;
	localparam logic [7:0] ASC_DOWN  = 8'h42;
	localparam logic [7:0] ASC_RIGHT = 8'h43;
	localparam logic [7:0] ASC_LEFT  = 8'h44;
	localparam logic [7:0] ASC_TILDE = 8'h7E;
	localparam logic [7:0] ASC_FINAL_LO = 8'h40;
	localparam logic [7:0] ASC_DIG_1 = 8'h31;
	localparam logic [7:0] ASC_DIG_2 = 8'h32;
	localparam logic [7:0] ASC_DIG_3 = 8'h33;
	localparam logic [7:0] ASC_DIG_4 = 8'h34;
	localparam logic [7:0] ASC_DIG_5 = 8'h35;
	localparam logic [7:0] ASC_DIG_6 = 8'h36;
	localparam logic [7:0] ASC_DIG_7 = 8'h37;
	localparam logic [7:0] ASC_DIG_8 = 8'h38;
	localparam logic [7:0] CTRL_LAST = 8'd26;
	localparam logic [7:0] CTRL_TO_LC = 8'h60;

	// Key codes
	localparam logic [7:0] KEY_NONE  = 8'h00;
	localparam logic [7:0] KEY_UP    = 8'h10;
	localparam logic [7:0] KEY_DOWN  = 8'h11;
	localparam logic [7:0] KEY_RIGHT = 8'h12;
	localparam logic [7:0] KEY_LEFT  = 8'h13;
	localparam logic [7:0] KEY_INS   = 8'h14;
	localparam logic [7:0] KEY_DEL   = 8'h7F;
	localparam logic [7:0] KEY_PGUP  = 8'h15;
	localparam logic [7:0] KEY_PGDN  = 8'h16;
	localparam logic [7:0] KEY_HOME  = 8'h17;
	localparam logic [7:0] KEY_END   = 8'h18;

	// Operation codes of an input word
	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_POP    = 1'b1;

	// Command queue between parser and executor
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;

	typedef struct packed {
		logic       pop;
		logic       rec;
		logic [7:0] rec_code;
		logic       push;
		logic [7:0] push_code;
		logic       ctrl;
	} stkd_cmd_t;

endpackage

FILE: src/stkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stkd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/stkd_cmdq.sv
// Two-entry command queue between the parser and the executor.
// Depends on stkd_pkg for the command word.
module stkd_cmdq
	import stkd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  stkd_cmd_t wr_cmd,
	output logic      full,
	output logic      rd_valid,
	output stkd_cmd_t rd_cmd,
	input  logic      rd_en
);

	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	stkd_cmd_t             slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0]      cnt_q;

	assign full     = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

FILE: src/stkd_front.sv
// Parser front end: accepts words, tracks escape sequences and the ctrl flag,
// and turns each word into one command. Depends on stkd_pkg.
module stkd_front
	import stkd_pkg::*;
#(
	parameter int ESCAPE_MAX = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	output stkd_cmd_t  cmd
);

	localparam int LEN_W = $clog2(ESCAPE_MAX + 1);

	typedef enum logic [1:0] {
		M_NORMAL,
		M_ESC,
		M_CSI,
		M_SS3
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [7:0]       first_q, first_d;
	logic [7:0]       second_q, second_d;
	logic [LEN_W-1:0] len_q, len_d, len_inc;
	logic             ctrl_q, ctrl_d;
	logic             is_ctl, is_ws, is_prn;
	logic [7:0]       key;

	always_comb begin
		cmd      = '0;
		mode_d   = mode_q;
		first_d  = first_q;
		second_d = second_q;
		len_d    = len_q;
		ctrl_d   = ctrl_q;
		key      = KEY_NONE;
		len_inc  = (len_q < LEN_W'(ESCAPE_MAX)) ? len_q + 1'b1 : len_q;
		is_ws    = (rx_byte == ASC_BS) || (rx_byte == ASC_TAB) ||
		           (rx_byte == ASC_LF) || (rx_byte == ASC_CR);
		is_ctl   = (rx_byte != 8'h00) && (rx_byte <= CTRL_LAST) && !is_ws;
		is_prn   = (rx_byte >= ASC_SPACE) && !rx_byte[7];
		if (operation == OP_POP) begin
			cmd.pop = 1'b1;
		end else begin
			unique case (mode_q)
				M_NORMAL: begin
					if (rx_byte == ASC_ESC) begin
						mode_d = M_ESC;
						len_d  = '0;
					end else begin
						if (is_ctl) begin
							ctrl_d = 1'b1;
						end
						cmd.rec       = is_ctl || is_ws || is_prn;
						cmd.rec_code  = rx_byte;
						cmd.push      = 1'b1;
						// lowercase folds to its control code once ctrl is latched
						if (ctrl_d && rx_byte >= ASC_LC_A && rx_byte <= ASC_LC_Z) begin
							cmd.push_code = rx_byte - CTRL_TO_LC;
						end else begin
							cmd.push_code = rx_byte;
						end
					end
				end
				M_ESC: begin
					if (len_q == '0) begin
						first_d = rx_byte;
					end else if (len_q == LEN_W'(1)) begin
						second_d = rx_byte;
					end
					len_d = len_inc;
					if (rx_byte == ASC_LBRK) begin
						mode_d = M_CSI;
					end else if (rx_byte == ASC_SS3) begin
						mode_d = M_SS3;
					end else begin
						mode_d = M_NORMAL;
					end
				end
				M_CSI, M_SS3: begin
					if (len_q == '0) begin
						first_d = rx_byte;
					end else if (len_q == LEN_W'(1)) begin
						second_d = rx_byte;
					end
					len_d = len_inc;
					if ((rx_byte >= ASC_FINAL_LO && rx_byte <= ASC_TILDE) ||
					    len_inc >= LEN_W'(ESCAPE_MAX)) begin
						mode_d = M_NORMAL;
						if (first_d == ASC_LBRK && len_inc >= LEN_W'(2)) begin
							case (rx_byte)
								ASC_UP:    key = KEY_UP;
								ASC_DOWN:  key = KEY_DOWN;
								ASC_RIGHT: key = KEY_RIGHT;
								ASC_LEFT:  key = KEY_LEFT;
								ASC_TILDE: begin
									if (len_inc >= LEN_W'(3)) begin
										unique case (second_d) inside
											ASC_DIG_2:            key = KEY_INS;
											ASC_DIG_3:            key = KEY_DEL;
											ASC_DIG_5:            key = KEY_PGUP;
											ASC_DIG_6:            key = KEY_PGDN;
											ASC_DIG_1, ASC_DIG_7: key = KEY_HOME;
											ASC_DIG_4, ASC_DIG_8: key = KEY_END;
											default:              key = KEY_NONE;
										endcase
									end
								end
								default: key = KEY_NONE;
							endcase
						end
						cmd.rec       = (key != KEY_NONE);
						cmd.push      = (key != KEY_NONE);
						cmd.rec_code  = key;
						cmd.push_code = key;
					end
				end
			endcase
		end
		cmd.ctrl = ctrl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			len_q  <= '0;
			ctrl_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			ctrl_q <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

endmodule

FILE: src/stkd_back.sv
// Executor back end: serial key-set scan, output ring push and pop, and the
// result register. Depends on stkd_pkg and stkd_ram.
module stkd_back
	import stkd_pkg::*;
#(
	parameter int RING_DEPTH   = 256,
	parameter int KEY_SET_SIZE = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	input  stkd_cmd_t                           cmd,
	output logic                                cmd_take,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                char_valid,
	output logic [7:0]                          char_out,
	output logic [$clog2(KEY_SET_SIZE+1)-1:0]   pressed_count,
	output logic                                ctrl_latched
);

	localparam int CNT_W  = $clog2(KEY_SET_SIZE + 1);
	localparam int KIDX_W = (KEY_SET_SIZE > 1) ? $clog2(KEY_SET_SIZE) : 1;
	localparam int RA_W   = $clog2(RING_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PUSH,
		S_POPRD,
		S_POPWT,
		S_DONE
	} state_t;

	state_t          state_q;
	stkd_cmd_t       cur_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]      key_set_q [KEY_SET_SIZE];
	logic [RA_W-1:0] head_q, tail_q, head_nx, tail_nx;
	logic            pvalid_q;
	logic [7:0]      pchar_q;
	logic            res_valid_q, char_valid_q, ctrl_q;
	logic [7:0]      char_q;
	logic            scan_end, key_hit, key_add, ring_empty;
	logic            ram_we, ram_re;
	logic [7:0]      ram_rdata;

	assign head_nx    = (head_q == RA_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx    = (tail_q == RA_W'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign ring_empty = (head_q == tail_q);
	assign scan_end   = (scan_q == count_q);
	assign key_hit    = !scan_end && (key_set_q[scan_q[KIDX_W-1:0]] == cur_q.rec_code);
	assign key_add    = (state_q == S_SCAN) && scan_end && (count_q < CNT_W'(KEY_SET_SIZE));
	assign cmd_take   = (state_q == S_IDLE) && cmd_valid && !res_valid_q;
	assign ram_we     = (state_q == S_PUSH);
	assign ram_re     = (state_q == S_POPRD) && !ring_empty;

	assign res_valid     = res_valid_q;
	assign char_valid    = char_valid_q;
	assign char_out      = char_q;
	assign pressed_count = count_q;
	assign ctrl_latched  = ctrl_q;

	stkd_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (cur_q.push_code),
		.re    (ram_re),
		.raddr (tail_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			scan_q       <= '0;
			count_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			pvalid_q     <= 1'b0;
			pchar_q      <= '0;
			res_valid_q  <= 1'b0;
			char_valid_q <= 1'b0;
			char_q       <= '0;
			ctrl_q       <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cur_q    <= cmd;
						scan_q   <= '0;
						pvalid_q <= 1'b0;
						pchar_q  <= '0;
						if (cmd.rec) begin
							state_q <= S_SCAN;
						end else if (cmd.push) begin
							state_q <= S_PUSH;
						end else if (cmd.pop) begin
							state_q <= S_POPRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_end || key_hit) begin
						if (key_add) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= cur_q.push ? S_PUSH : S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_PUSH: begin
					// a full ring drops its oldest entry
					head_q <= head_nx;
					if (head_nx == tail_q) begin
						tail_q <= tail_nx;
					end
					state_q <= S_DONE;
				end
				S_POPRD: begin
					if (ring_empty) begin
						state_q <= S_DONE;
					end else begin
						tail_q  <= tail_nx;
						state_q <= S_POPWT;
					end
				end
				S_POPWT: begin
					pvalid_q <= 1'b1;
					pchar_q  <= ram_rdata;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					res_valid_q  <= 1'b1;
					char_valid_q <= pvalid_q;
					char_q       <= pchar_q;
					ctrl_q       <= cur_q.ctrl;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (key_add) begin
			key_set_q[count_q[KIDX_W-1:0]] <= cur_q.rec_code;
		end
	end

endmodule

FILE: src/serial_terminal_key_decoder_core.sv
// Serial terminal key decoder: VT100-style escape parsing into a ring of keys.
// Each word is parsed combinationally into the command queue; the executor then takes it and
//   runs the key-set scan, a ring push or a ring read and wait, and the done state into the result register.
// The executor handles one command at a time and takes no new one while a result is stalled;
//   a two-entry command queue lets the parser take words while the executor is busy.
// Reset: arst_n clears parser mode, ctrl flag, key count and ring pointers.
module serial_terminal_key_decoder_core
	import stkd_pkg::*;
#(
	parameter int RING_DEPTH   = 256,
	parameter int KEY_SET_SIZE = 10,
	parameter int ESCAPE_MAX   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [7:0]                        rx_byte,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              char_valid,
	output logic [7:0]                        char_out,
	output logic [$clog2(KEY_SET_SIZE+1)-1:0] pressed_count,
	output logic                              ctrl_latched
);

	logic      in_accept;
	logic      q_full;
	logic      q_valid;
	logic      q_take;
	stkd_cmd_t front_cmd;
	stkd_cmd_t q_cmd;

	// hold input words back only while the command queue is full
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	// front: classify each word into one command and advance parser state
	stkd_front #(
		.ESCAPE_MAX (ESCAPE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.operation (operation),
		.rx_byte   (rx_byte),
		.cmd       (front_cmd)
	);

	// queue: decouple the parser from the executor
	stkd_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_accept),
		.wr_cmd   (front_cmd),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd),
		.rd_en    (q_take)
	);

	// back: scan the key set, push or pop the ring, drive the result word
	stkd_back #(
		.RING_DEPTH   (RING_DEPTH),
		.KEY_SET_SIZE (KEY_SET_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_valid),
		.cmd           (q_cmd),
		.cmd_take      (q_take),
		.res_valid     (out_valid),
		.res_stall     (out_stall),
		.char_valid    (char_valid),
		.char_out      (char_out),
		.pressed_count (pressed_count),
		.ctrl_latched  (ctrl_latched)
	);

endmodule
